### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while arst_n is low.
`define SAA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form of the check above.
`define SAA_ASSERT_IMP(lbl, ante, cons, msg) \
	`SAA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### src/saa_pkg.sv
package saa_pkg;

	localparam int ARENA_BYTES_DEF  = 65536;
	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 8;

	localparam int HANDLE_W = 16;
	localparam int SIZE_W   = 17;
	localparam int ALIGN_W  = 4;
	localparam int PAD_W    = 13;
	localparam int ENTRY_W  = SIZE_W + PAD_W;

	localparam logic [ALIGN_W-1:0] MAX_ALIGN_LOG2 = 4'd12;
	localparam logic [SIZE_W-1:0]  LIMIT_RESET    = 17'h10000;
	localparam int                 LIMIT_MAX      = 131071;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_REALLOC = 2'd1,
		CMD_FREE    = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_IGNORED = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} fsm_t;

	typedef struct packed {
		cmd_t                command;
		logic                has_handle;
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
		logic [ALIGN_W-1:0]  alignment_log2;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		status_t             status;
		logic                must_copy;
		logic [SIZE_W-1:0]   used;
	} res_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  top;
		logic [SIZE_W-1:0]  last;
		logic               wr_en;
		logic [ENTRY_W-1:0] wr_entry;
		res_t               res;
	} upd_t;

endpackage

### src/saa_ram.sv
module saa_ram #(
	parameter int WIDTH  = 30,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/saa_calc.sv
module saa_calc import saa_pkg::*; #(
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int DEPTH_W      = $clog2(MAX_BLOCKS + 1)
) (
	input  req_t               req,
	input  logic [SIZE_W-1:0]  eff_limit,
	input  logic [SIZE_W-1:0]  top,
	input  logic [SIZE_W-1:0]  last,
	input  logic [DEPTH_W-1:0] depth,
	input  logic [ENTRY_W-1:0] top_entry,
	output upd_t               upd,
	output logic [DEPTH_W-1:0] depth_nxt
);

	localparam logic [13:0]        HDR  = 14'(HEADER_BYTES);
	localparam logic [DEPTH_W-1:0] FULL = DEPTH_W'(MAX_BLOCKS);

	logic [13:0]       amask, pad0, need, padx, pad;
	logic [SIZE_W:0]   s, s_end, h_end, top_start;
	logic [SIZE_W-1:0] top_diff, top_pad;
	logic              bad_align, full, nospace, is_top, in_range;
	logic              do_alloc, do_pop, do_push, do_clear, do_resize;
	status_t           st, alloc_st;

	// Header-aware padding: round up to the alignment, then add whole
	// alignment steps until the header fits.
	always_comb begin
		amask     = ~(14'h3FFF << req.alignment_log2);
		pad0      = (14'd0 - top[13:0]) & amask;
		need      = HDR - pad0;
		padx      = pad0 + ((need + amask) & ~amask);
		pad       = (pad0 < HDR) ? padx : pad0;
		s         = {1'b0, top} + 18'(pad);
		s_end     = s + {1'b0, req.size};
		bad_align = req.alignment_log2 > MAX_ALIGN_LOG2;
		full      = depth >= FULL;
		nospace   = full || (s > 18'h0FFFF) || (s_end > {1'b0, eff_limit});
		alloc_st  = bad_align ? ST_RANGE : (nospace ? ST_NOSPACE : ST_OK);
	end

	always_comb begin
		top_pad   = {4'd0, top_entry[ENTRY_W-1:SIZE_W]};
		top_diff  = top_entry[SIZE_W-1:0];
		top_start = {1'b0, last} + {1'b0, top_pad};
		is_top    = (depth != '0) && ({2'b00, req.handle} == top_start);
		in_range  = {1'b0, req.handle} < eff_limit;
		h_end     = {2'b00, req.handle} + {1'b0, req.size};
	end

	always_comb begin
		st        = ST_OK;
		do_alloc  = 1'b0;
		do_pop    = 1'b0;
		do_clear  = 1'b0;
		do_resize = 1'b0;
		case (req.command)
			CMD_ALLOC: begin
				do_alloc = 1'b1;
			end
			CMD_REALLOC: begin
				if (!req.has_handle) begin
					do_alloc = 1'b1;
				end else if (!in_range) begin
					st = ST_RANGE;
				end else if (req.size == '0) begin
					if (is_top) do_pop = 1'b1;
					else st = ST_IGNORED;
				end else if (is_top) begin
					if (h_end > {1'b0, eff_limit}) st = ST_NOSPACE;
					else do_resize = 1'b1;
				end else begin
					do_alloc = 1'b1;
				end
			end
			CMD_FREE: begin
				if (req.has_handle) begin
					if (!in_range) st = ST_RANGE;
					else if (is_top) do_pop = 1'b1;
					else st = ST_IGNORED;
				end
			end
			CMD_CLEAR: begin
				do_clear = 1'b1;
			end
			default: begin
				st = ST_OK;
			end
		endcase
		if (do_alloc) begin
			st = alloc_st;
		end
		do_push = do_alloc && (alloc_st == ST_OK);
	end

	always_comb begin
		upd.top      = top;
		upd.last     = last;
		depth_nxt    = depth;
		upd.wr_en    = do_push;
		upd.wr_entry = {pad[PAD_W-1:0], top - last};
		upd.res.handle    = '0;
		upd.res.must_copy = 1'b0;
		if (do_clear) begin
			upd.top   = '0;
			upd.last  = '0;
			depth_nxt = '0;
		end else if (do_pop) begin
			upd.top   = last;
			upd.last  = last - top_diff;
			depth_nxt = depth - 1'b1;
		end else if (do_resize) begin
			upd.top        = h_end[SIZE_W-1:0];
			upd.res.handle = req.handle;
		end else if (do_push) begin
			upd.top           = s_end[SIZE_W-1:0];
			upd.last          = top;
			depth_nxt         = depth + 1'b1;
			upd.res.handle    = s[HANDLE_W-1:0];
			upd.res.must_copy = (req.command == CMD_REALLOC) && req.has_handle;
		end
		upd.res.status = st;
		upd.res.used   = upd.top;
	end

endmodule

### src/stack_arena_allocator.sv
// done is registered from the execute state: it pulses once the request has passed state_q and done_q.
// No new request is taken while busy: the top entry is read in the accept cycle
// and a pushed entry is written in the execute cycle.
// busy is high for the one execute cycle; results cannot be held off.
// Reset (arst_n low) empties the stack and sets arena_limit to 65536;
// the header memory is not cleared and needs no clearing pass.
module stack_arena_allocator import saa_pkg::*; #(
	parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          command,
	input  logic                has_handle,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [SIZE_W-1:0]   size,
	input  logic [ALIGN_W-1:0]  alignment_log2,
	output logic                done,
	output logic [HANDLE_W-1:0] result_handle,
	output logic [1:0]          status,
	output logic                must_copy,
	output logic [SIZE_W-1:0]   used_bytes
);

	localparam int                DEPTH_W = $clog2(MAX_BLOCKS + 1);
	localparam int                ADDR_W  = $clog2(MAX_BLOCKS);
	localparam int                CAP_I   = (ARENA_BYTES > LIMIT_MAX) ? LIMIT_MAX : ARENA_BYTES;
	localparam logic [SIZE_W-1:0] CAP     = SIZE_W'(CAP_I);

	fsm_t               state_q, state_nxt;
	logic               accept, exec;
	req_t               req_q;
	logic [SIZE_W-1:0]  limit_q, eff_limit;
	logic [SIZE_W-1:0]  top_q, last_q;
	logic [DEPTH_W-1:0] depth_q, depth_nxt, depth_m1;
	logic [ENTRY_W-1:0] top_entry;
	upd_t               upd;
	res_t               res_q;
	logic               done_q;

	// Config port
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == 1'b0) ? {15'd0, limit_q} : 32'd0;
	assign eff_limit = (limit_q < CAP) ? limit_q : CAP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			limit_q <= pwdata[SIZE_W-1:0];
		end
	end

	// Sequencer
	assign accept = start && !busy;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b0;
		exec = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
			end
			S_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.command        <= cmd_t'(command);
			req_q.has_handle     <= has_handle;
			req_q.handle         <= handle;
			req_q.size           <= size;
			req_q.alignment_log2 <= alignment_log2;
		end
	end

	// Header stack: read the top entry while idle, push in the execute cycle
	assign depth_m1 = depth_q - 1'b1;

	saa_ram #(
		.WIDTH  (ENTRY_W),
		.DEPTH  (MAX_BLOCKS),
		.ADDR_W (ADDR_W)
	) u_hdr_ram (
		.clk   (clk),
		.we    (exec && upd.wr_en),
		.waddr (depth_q[ADDR_W-1:0]),
		.wdata (upd.wr_entry),
		.raddr (depth_m1[ADDR_W-1:0]),
		.rdata (top_entry)
	);

	saa_calc #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES),
		.DEPTH_W      (DEPTH_W)
	) u_calc (
		.req       (req_q),
		.eff_limit (eff_limit),
		.top       (top_q),
		.last      (last_q),
		.depth     (depth_q),
		.top_entry (top_entry),
		.upd       (upd),
		.depth_nxt (depth_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			last_q  <= '0;
			depth_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec) begin
				top_q   <= upd.top;
				last_q  <= upd.last;
				depth_q <= depth_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_q <= upd.res;
		end
	end

	assign done          = done_q;
	assign result_handle = res_q.handle;
	assign status        = res_q.status;
	assign must_copy     = res_q.must_copy;
	assign used_bytes    = res_q.used;

endmodule

### src/saa_checker.sv
`include "assert_macros.svh"

module saa_checker import saa_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [HANDLE_W-1:0] result_handle,
	input logic [1:0]          status,
	input logic                must_copy
);

	`SAA_ASSERT_IMP(a_busy_after_accept, start && !busy, ##1 busy, "busy missing after beat")
	`SAA_ASSERT_IMP(a_done_latency, start && !busy, ##2 done, "result not two cycles after beat")
	`SAA_ASSERT_IMP(a_done_from_busy, done, $past(busy) && !busy, "done without execute cycle")
	`SAA_ASSERT_IMP(a_fail_clean, done && (status != ST_OK),
		(result_handle == '0) && !must_copy, "failed request returned a block")

endmodule

bind stack_arena_allocator saa_checker u_saa_checker (.*);

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import saa_pkg::*;

	localparam logic [2:0] ADDR_ARENA_LIMIT = 3'd0;
	localparam int PHASES = 8;

	class arena_scoreboard;
		logic [16:0] arena_limit;
		logic [16:0] top;
		logic [16:0] base_mark;
		logic [16:0] hdr_back [MAX_BLOCKS_DEF];
		logic [12:0] hdr_pad [MAX_BLOCKS_DEF];
		int unsigned depth;
		res_t outcomes_due [$];
		int errors;
		int checked;
		int by_status [4];
		int moves;
		int deepest;

		function new();
			arena_limit = LIMIT_RESET;
			top = '0;
			base_mark = '0;
			depth = 0;
			errors = 0;
			checked = 0;
			by_status = '{0, 0, 0, 0};
			moves = 0;
			deepest = 0;
		endfunction

		function void set_limit(int v);
			arena_limit = v[16:0];
		endfunction

		function int eff_limit();
			return (arena_limit > ARENA_BYTES_DEF) ? ARENA_BYTES_DEF : int'(arena_limit);
		endfunction

		function int pending();
			return outcomes_due.size();
		endfunction

		function logic [15:0] top_block_handle();
			logic [16:0] h;
			if (depth == 0)
				return '0;
			h = base_mark + hdr_pad[depth - 1];
			return h[15:0];
		endfunction

		function bit is_top_block(int h);
			return depth != 0 && h == int'(base_mark) + int'(hdr_pad[depth - 1]);
		endfunction

		// Header-aware padding: bump by one alignment until the header fits.
		function status_t carve_block(int sz, int lg, output int at);
			int a;
			int pad;
			int s;
			at = 0;
			if (lg > MAX_ALIGN_LOG2)
				return ST_RANGE;
			a = 1 << lg;
			pad = (a - (int'(top) & (a - 1))) & (a - 1);
			if (pad < HEADER_BYTES_DEF)
				pad += ((HEADER_BYTES_DEF - pad + a - 1) >> lg) << lg;
			if (depth >= MAX_BLOCKS_DEF)
				return ST_NOSPACE;
			s = int'(top) + pad;
			if (s > 65535 || s + sz > eff_limit())
				return ST_NOSPACE;
			hdr_back[depth] = top - base_mark;
			hdr_pad[depth] = pad[12:0];
			depth++;
			base_mark = top;
			top = s + sz;
			at = s;
			return ST_OK;
		endfunction

		function void pop_block();
			logic [16:0] back;
			back = hdr_back[depth - 1];
			top = base_mark;
			base_mark = base_mark - back;
			depth--;
		endfunction

		function void take_request(req_t r);
			res_t e;
			status_t st;
			int at;
			int h;
			int sz;
			logic copy;
			at = 0;
			st = ST_OK;
			copy = 1'b0;
			h = r.handle;
			sz = r.size;
			case (r.command)
				CMD_ALLOC: begin
					st = carve_block(sz, r.alignment_log2, at);
				end
				CMD_REALLOC: begin
					if (!r.has_handle) begin
						st = carve_block(sz, r.alignment_log2, at);
					end else if (h >= eff_limit()) begin
						st = ST_RANGE;
					end else if (sz == 0) begin
						if (is_top_block(h))
							pop_block();
						else
							st = ST_IGNORED;
					end else if (is_top_block(h)) begin
						if (h + sz > eff_limit()) begin
							st = ST_NOSPACE;
						end else begin
							top = h + sz;
							at = h;
						end
					end else begin
						st = carve_block(sz, r.alignment_log2, at);
						copy = (st == ST_OK);
					end
				end
				CMD_FREE: begin
					if (r.has_handle) begin
						if (h >= eff_limit())
							st = ST_RANGE;
						else if (is_top_block(h))
							pop_block();
						else
							st = ST_IGNORED;
					end
				end
				default: begin
					top = '0;
					base_mark = '0;
					depth = 0;
				end
			endcase
			if (st != ST_OK) begin
				at = 0;
				copy = 1'b0;
			end
			e.handle = at[15:0];
			e.status = st;
			e.must_copy = copy;
			e.used = top;
			outcomes_due.push_back(e);
			if (depth > deepest)
				deepest = depth;
		endfunction

		function void compare(string name, logic [16:0] exp, logic [16:0] act);
			if (act !== exp) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp, act);
			end
		endfunction

		function void check_outcome(logic [15:0] h, logic [1:0] st, logic mc,
				logic [16:0] used);
			res_t e;
			if (outcomes_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: handle %0d status %0d used %0d",
					$time, h, st, used);
				return;
			end
			e = outcomes_due.pop_front();
			checked++;
			by_status[int'(e.status)]++;
			if (e.must_copy)
				moves++;
			compare("result_handle", 17'(e.handle), 17'(h));
			compare("status", 17'(e.status), 17'(st));
			compare("must_copy", 17'(e.must_copy), 17'(mc));
			compare("used_bytes", e.used, used);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [1:0] command;
	logic has_handle;
	logic [HANDLE_W-1:0] handle;
	logic [SIZE_W-1:0] size;
	logic [ALIGN_W-1:0] alignment_log2;
	logic done;
	logic [HANDLE_W-1:0] result_handle;
	logic [1:0] status;
	logic must_copy;
	logic [SIZE_W-1:0] used_bytes;

	arena_scoreboard sb;

	stack_arena_allocator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.has_handle     (has_handle),
		.handle         (handle),
		.size           (size),
		.alignment_log2 (alignment_log2),
		.done           (done),
		.result_handle  (result_handle),
		.status         (status),
		.must_copy      (must_copy),
		.used_bytes     (used_bytes)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_outcome(result_handle, status, must_copy, used_bytes);
	end

	function automatic req_t make_request(cmd_t c, logic hh, int h, int sz, int lg);
		req_t r;
		r.command = c;
		r.has_handle = hh;
		r.handle = h[15:0];
		r.size = sz[16:0];
		r.alignment_log2 = lg[3:0];
		return r;
	endfunction

	function automatic int pick_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return $urandom_range(0, 64);
		if (roll < 85)
			return $urandom_range(0, 1024);
		if (roll < 97)
			return $urandom_range(0, 16384);
		return $urandom_range(0, ARENA_BYTES_DEF);
	endfunction

	function automatic int pick_align();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return $urandom_range(0, 5);
		if (roll < 95)
			return $urandom_range(0, MAX_ALIGN_LOG2);
		return $urandom_range(MAX_ALIGN_LOG2 + 1, 15);
	endfunction

	// Mostly well-formed: free and resize aim at the live top block.
	function automatic req_t rand_request(int alloc_pct);
		req_t r;
		int roll;
		r = make_request(CMD_ALLOC, 1'($urandom_range(0, 1)), $urandom_range(0, 65535),
			pick_size(), pick_align());
		if ($urandom_range(0, 99) < alloc_pct)
			return r;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			r.command = CMD_REALLOC;
			if ($urandom_range(0, 3) == 0)
				r.size = '0;
		end else if (roll < 90) begin
			r.command = CMD_FREE;
		end else begin
			r.command = CMD_CLEAR;
			return r;
		end
		roll = $urandom_range(0, 99);
		if (roll < 70 && sb.depth != 0) begin
			r.has_handle = 1'b1;
			r.handle = sb.top_block_handle();
		end else if (roll < 80) begin
			r.has_handle = 1'b0;
		end else begin
			r.has_handle = 1'b1;
		end
		return r;
	endfunction

	// Leave start high on return so back-to-back beats need no extra edge.
	task automatic send(req_t r);
		start <= 1'b1;
		command <= r.command;
		has_handle <= r.has_handle;
		handle <= r.handle;
		size <= r.size;
		alignment_log2 <= r.alignment_log2;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.take_request(r);
	endtask

	task automatic pause_sender(int pct);
		while ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(int v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_ARENA_LIMIT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_limit(v);
	endtask

	initial begin
		#2ms;
		$display("Timeout waiting for the allocator");
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int limits [PHASES];
		int counts [PHASES];
		int idle_pct [PHASES];
		int alloc_pct [PHASES];
		int v;
		sb = new();
		limits = '{65536, 131071, 0, 300, 4096, -1, 65535, 1000};
		counts = '{120, 120, 30, 110, 110, 120, 110, 110};
		idle_pct = '{0, 70, 9, 70, 0, 9, 70, 0};
		alloc_pct = '{90, 40, 40, 40, 60, 40, 40, 90};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		command <= CMD_ALLOC;
		has_handle <= 1'b0;
		handle <= '0;
		size <= '0;
		alignment_log2 <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under the reset limit, then under a limit of 200
		send(make_request(CMD_ALLOC, 0, 0, 0, 0));
		send(make_request(CMD_ALLOC, 1, 12345, 100, 12));
		send(make_request(CMD_ALLOC, 0, 0, 1, 13));
		send(make_request(CMD_ALLOC, 0, 0, 1, 15));
		send(make_request(CMD_REALLOC, 0, 0, 24, 3));
		send(make_request(CMD_REALLOC, 1, sb.top_block_handle(), 200, 0));
		send(make_request(CMD_REALLOC, 1, sb.top_block_handle(), 1, 0));
		send(make_request(CMD_REALLOC, 1, 8, 16, 4));
		send(make_request(CMD_FREE, 0, 0, 0, 0));
		send(make_request(CMD_FREE, 1, 8, 0, 0));
		send(make_request(CMD_FREE, 1, sb.top_block_handle(), 0, 0));
		send(make_request(CMD_REALLOC, 1, sb.top_block_handle(), 0, 0));
		send(make_request(CMD_REALLOC, 1, sb.top_block_handle(), 65535, 0));
		send(make_request(CMD_ALLOC, 0, 0, 65536, 0));
		send(make_request(CMD_FREE, 1, sb.top_block_handle(), 0, 0));
		send(make_request(CMD_ALLOC, 0, 0, 65520, 0));
		send(make_request(CMD_ALLOC, 0, 0, 0, 0));
		send(make_request(CMD_REALLOC, 1, sb.top_block_handle(), 65520, 0));
		send(make_request(CMD_CLEAR, 1, 65535, 65536, 15));
		send(make_request(CMD_ALLOC, 1, 65535, 0, 0));
		drain();
		write_limit(200);
		send(make_request(CMD_FREE, 1, 65535, 0, 0));
		send(make_request(CMD_REALLOC, 1, 200, 5, 0));
		send(make_request(CMD_ALLOC, 0, 0, 300, 0));
		send(make_request(CMD_CLEAR, 0, 0, 0, 0));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			v = (limits[p] < 0) ? $urandom_range(0, LIMIT_MAX) : limits[p];
			write_limit(v);
			for (int n = 0; n < counts[p]; n++) begin
				pause_sender(idle_pct[p]);
				send(rand_request(alloc_pct[p]));
				if (p == 1 && n == 60)
					drain();
			end
		end

		drain();
		repeat (5) @(posedge clk);
		$display("Checked %0d requests over %0d limit settings: %0d ok, %0d no room,",
			sb.checked, PHASES + 1, sb.by_status[ST_OK], sb.by_status[ST_NOSPACE]);
		$display("  %0d ignored, %0d out of range; blocks moved on resize: %0d",
			sb.by_status[ST_IGNORED], sb.by_status[ST_RANGE], sb.moves);
		$display("Deepest stack: %0d of %0d", sb.deepest, MAX_BLOCKS_DEF);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/saa_pkg.sv
src/saa_ram.sv
src/saa_calc.sv
src/stack_arena_allocator.sv
src/saa_checker.sv
dv/testbench.sv
